/* rtl/tbm_pkg.sv */
// Shared constants, codes and types for the threshold binary morphology block.
`timescale 1ns / 1ps

package tbm_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_RADIUS = 7;

	localparam int PIX_W  = 8;
	localparam int THR_W  = 9;
	localparam int MODE_W = 2;
	localparam int RAD_W  = 3;
	localparam int FW_W   = 11;
	localparam int FH_W   = 14;
	localparam int CFG_IW = 3;
	localparam int CFG_DW = 14;

	localparam logic [PIX_W-1:0] PIX_ON = 8'd255;

	// cycles the input stays closed after a register write
	localparam int BUSY_CYC = 3;

	localparam logic [CFG_IW-1:0] REG_THRESHOLD    = 3'd0;
	localparam logic [CFG_IW-1:0] REG_OP_MODE      = 3'd1;
	localparam logic [CFG_IW-1:0] REG_RADIUS       = 3'd2;
	localparam logic [CFG_IW-1:0] REG_FRAME_WIDTH  = 3'd3;
	localparam logic [CFG_IW-1:0] REG_FRAME_HEIGHT = 3'd4;

	localparam logic [THR_W-1:0]  THR_RST  = 9'd128;
	localparam logic [MODE_W-1:0] MODE_RST = 2'd0;
	localparam logic [RAD_W-1:0]  RAD_RST  = 3'd1;
	localparam logic [FW_W-1:0]   FW_RST   = 11'd640;
	localparam logic [FH_W-1:0]   FH_RST   = 14'd480;

	localparam logic [MODE_W-1:0] MODE_ERODE  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DILATE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_OPEN   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_CLOSE  = 2'd3;

	typedef struct packed {
		logic en2;
		logic oe;
		logic last;
	} tag_t;

endpackage

/* rtl/tbm_if.sv */
// Stream and register-write channel interfaces of the morphology block.
`timescale 1ns / 1ps

interface tbm_pix_if;
	import tbm_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel;
	logic             flush;
	modport source (output valid, output pixel, output flush, input ready);
	modport sink (input valid, input pixel, input flush, output ready);
endinterface

interface tbm_res_if;
	import tbm_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] out_pixel;
	logic             last_of_frame;
	modport source (output valid, output out_pixel, output last_of_frame, input ready);
	modport sink (input valid, input out_pixel, input last_of_frame, output ready);
endinterface

interface tbm_cfg_if;
	import tbm_pkg::*;
	logic              valid;
	logic              ready;
	logic [CFG_IW-1:0] index;
	logic [CFG_DW-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/tbm_stage.sv */
// One morphology stage: column line buffer, separable window reduce, edge bypass.
`timescale 1ns / 1ps

module tbm_stage
	import tbm_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_RADIUS = DEF_MAX_RADIUS,
	localparam int RB = $clog2(MAX_RADIUS + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            last,
	input  logic            bit_in,
	input  logic            grow,
	input  logic [RB-1:0]   r,
	input  logic [FW_W-1:0] w,
	input  logic [FH_W-1:0] h,
	output logic            res
);

	localparam int HW = 2 * MAX_RADIUS;
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int XW = (CW + 1 > FW_W) ? CW + 1 : FW_W;
	localparam int RW = FH_W + 1;

	logic [HW-1:0] mem [MAX_WIDTH];
	logic [HW-1:0] rdata_q;
	logic [HW-1:0] red_q;
	logic [HW-1:0] ctr_q;
	logic [CW-1:0] col_q, col_nxt, raddr;
	logic [RW-1:0] row_q, row_nxt;
	logic [HW:0]   vcol, wmask, hred_vec, hctr_vec;
	logic          vred, hred, center, interior, wrap;

	always_comb begin
		vcol = {rdata_q, bit_in};
		for (int i = 0; i <= HW; i++) begin
			wmask[i] = (i <= 2 * int'(r));
		end
		vred     = grow ? |(vcol & wmask) : &(vcol | ~wmask);
		hred_vec = {red_q, vred};
		hctr_vec = {ctr_q, vcol[r]};
		hred     = grow ? |(hred_vec & wmask) : &(hred_vec | ~wmask);
		center   = hctr_vec[r];
		// newest pixel of the window sits at (row_q, col_q)
		interior = (int'(row_q) >= 2 * int'(r)) && (int'(row_q) < int'(h)) &&
			(int'(col_q) >= 2 * int'(r));
		res      = interior ? hred : center;
		wrap     = (XW'(col_q) + XW'(1)) == XW'(w);
		col_nxt  = (last || wrap) ? '0 : col_q + 1'b1;
		row_nxt  = last ? '0 : (wrap ? row_q + 1'b1 : row_q);
		raddr    = en ? col_nxt : col_q;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mem[col_q] <= vcol[HW-1:0];
		end
		if (en && raddr == col_q) begin
			rdata_q <= vcol[HW-1:0];
		end else begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red_q <= hred_vec[HW-1:0];
			ctr_q <= hctr_vec[HW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (en) begin
			col_q <= col_nxt;
			row_q <= row_nxt;
		end
	end

endmodule

/* rtl/threshold_binary_morphology_top.sv */
// Top level: register file, frame sequencing, two morphology stages, output skid.
`timescale 1ns / 1ps

// Takes one word per clock on pix unless the output buffer is full or a
// register write is settling, and returns one binary pixel (0 or 255) per
// counted word on res, in raster order, once the window has filled: with
// W*H pixels per frame and L = r*W + r, output k leaves for input word k + L
// (erode, dilate) or k + 2L (open, close), so W*H + L (or 2L) words, the tail
// being flush words, complete a frame. Inside the block an item is registered
// ahead of each stage on its way to the output buffer, each stage reducing
// against a registered column line buffer of MAX_WIDTH words of 2*MAX_RADIUS
// bits. Registers are sampled at the first word of each frame; after a register
// write the input stays closed while the frame size and lag products settle.
module threshold_binary_morphology_top
	import tbm_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
	input  logic      clk,
	input  logic      arst_n,
	tbm_pix_if.sink   pix,
	tbm_res_if.source res,
	tbm_cfg_if.sink   cfg
);

	localparam int RB = $clog2(MAX_RADIUS + 1);
	localparam int TW = $clog2(MAX_WIDTH * ((1 << FH_W) - 1) +
		2 * (MAX_RADIUS * MAX_WIDTH + MAX_RADIUS) + 2);
	localparam int BW = $clog2(BUSY_CYC + 1);

	// register file
	logic [THR_W-1:0]  thr_q;
	logic [MODE_W-1:0] mode_q;
	logic [RAD_W-1:0]  rad_q;
	logic [FW_W-1:0]   fw_q;
	logic [FH_W-1:0]   fh_q;
	logic [BW-1:0]     busy_q;

	// derived frame settings
	logic [FW_W-1:0] dw_c, dw_q;
	logic [FH_W-1:0] dh_c, dh_q;
	logic [RB-1:0]   dr_c, dr_q;
	logic [TW-1:0]   dn_q, dlag1_q, dlag_q, dend_q;

	// latched per frame
	logic [THR_W-1:0] lthr_q;
	logic             ltwo_q, lgrow_q;
	logic [FW_W-1:0]  lw_q;
	logic [FH_W-1:0]  lh_q;
	logic [RB-1:0]    lr_q;
	logic [TW-1:0]    ln_q, llag1_q, llag_q, lend_q;

	logic [TW-1:0]    t_q;
	logic             frame0, acc, adv, counted, in_range, tbit;
	logic [THR_W-1:0] cur_thr;
	logic             cur_two;
	logic [TW-1:0]    cur_n, cur_lag1, cur_lag, cur_end;
	tag_t             tag_c, tag_s1, tag_s2;
	logic             v_s1, v_s2, bit_s1, bit_s2;
	logic             res1, res2, en1, en2;
	logic             push, pop, pbit;
	logic [1:0]       cnt_q;
	logic [1:0]       sk_bit_q, sk_last_q;
	logic             sk_idx;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= THR_RST;
			mode_q <= MODE_RST;
			rad_q  <= RAD_RST;
			fw_q   <= FW_RST;
			fh_q   <= FH_RST;
			busy_q <= BW'(BUSY_CYC);
		end else begin
			if (cfg.valid) begin
				busy_q <= BW'(BUSY_CYC);
				unique case (cfg.index)
					REG_THRESHOLD:    thr_q  <= cfg.data[THR_W-1:0];
					REG_OP_MODE:      mode_q <= cfg.data[MODE_W-1:0];
					REG_RADIUS:       rad_q  <= cfg.data[RAD_W-1:0];
					REG_FRAME_WIDTH:  fw_q   <= cfg.data[FW_W-1:0];
					REG_FRAME_HEIGHT: fh_q   <= cfg.data[FH_W-1:0];
					default: ;
				endcase
			end else if (busy_q != '0) begin
				busy_q <= busy_q - 1'b1;
			end
		end
	end

	always_comb begin
		dw_c = (fw_q == '0) ? FW_W'(1) :
			((int'(fw_q) > MAX_WIDTH) ? FW_W'(MAX_WIDTH) : fw_q);
		dh_c = (fh_q == '0) ? FH_W'(1) : fh_q;
		dr_c = (int'(rad_q) > MAX_RADIUS) ? RB'(MAX_RADIUS) : RB'(rad_q);
	end

	always_ff @(posedge clk) begin
		dw_q    <= dw_c;
		dh_q    <= dh_c;
		dr_q    <= dr_c;
		dn_q    <= TW'(dw_c) * TW'(dh_c);
		dlag1_q <= TW'(dr_c) * TW'(dw_c) + TW'(dr_c);
		dlag_q  <= mode_q[1] ? (dlag1_q << 1) : dlag1_q;
		dend_q  <= dlag_q + dn_q - TW'(1);
	end

	// frame sequencing
	assign adv       = (cnt_q != 2'd2);
	assign pix.ready = adv && (busy_q == '0);
	assign acc       = pix.valid && pix.ready;

	always_comb begin
		frame0   = (t_q == '0);
		cur_thr  = frame0 ? thr_q : lthr_q;
		cur_two  = frame0 ? mode_q[1] : ltwo_q;
		cur_n    = frame0 ? dn_q : ln_q;
		cur_lag1 = frame0 ? dlag1_q : llag1_q;
		cur_lag  = frame0 ? dlag_q : llag_q;
		cur_end  = frame0 ? dend_q : lend_q;
		in_range = (t_q < cur_n);
		counted  = !(in_range && pix.flush);
		tbit     = in_range && ({1'b0, pix.pixel} < cur_thr);
		tag_c.en2  = cur_two && (t_q >= cur_lag1);
		tag_c.oe   = (t_q >= cur_lag) && (t_q <= cur_end);
		tag_c.last = tag_c.oe && (t_q == cur_end);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_q <= '0;
		end else if (acc && counted) begin
			t_q <= tag_c.last ? '0 : t_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && frame0) begin
			lthr_q  <= thr_q;
			ltwo_q  <= mode_q[1];
			lgrow_q <= (mode_q == MODE_DILATE) || (mode_q == MODE_CLOSE);
			lw_q    <= dw_q;
			lh_q    <= dh_q;
			lr_q    <= dr_q;
			ln_q    <= dn_q;
			llag1_q <= dlag1_q;
			llag_q  <= dlag_q;
			lend_q  <= dend_q;
		end
	end

	// pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= acc && counted;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1 <= tag_c;
			bit_s1 <= tbit;
			tag_s2 <= tag_s1;
			bit_s2 <= res1;
		end
	end

	assign en1 = adv && v_s1;
	assign en2 = adv && v_s2 && tag_s2.en2;

	tbm_stage #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_RADIUS (MAX_RADIUS)
	) u_stage1 (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en1),
		.last   (tag_s1.last),
		.bit_in (bit_s1),
		.grow   (lgrow_q),
		.r      (lr_q),
		.w      (lw_q),
		.h      (lh_q),
		.res    (res1)
	);

	tbm_stage #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_RADIUS (MAX_RADIUS)
	) u_stage2 (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en2),
		.last   (tag_s2.last),
		.bit_in (bit_s2),
		.grow   (!lgrow_q),
		.r      (lr_q),
		.w      (lw_q),
		.h      (lh_q),
		.res    (res2)
	);

	// output skid, two words
	assign push   = adv && v_s2 && tag_s2.oe;
	assign pbit   = ltwo_q ? res2 : bit_s2;
	assign pop    = res.valid && res.ready;
	assign sk_idx = cnt_q[0] && !pop;

	always_ff @(posedge clk) begin
		if (push && !sk_idx) begin
			sk_bit_q[0]  <= pbit;
			sk_last_q[0] <= tag_s2.last;
		end else if (pop) begin
			sk_bit_q[0]  <= sk_bit_q[1];
			sk_last_q[0] <= sk_last_q[1];
		end
		if (push && sk_idx) begin
			sk_bit_q[1]  <= pbit;
			sk_last_q[1] <= tag_s2.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	assign res.valid         = (cnt_q != '0);
	assign res.out_pixel     = sk_bit_q[0] ? PIX_ON : '0;
	assign res.last_of_frame = sk_last_q[0];

`ifndef NO_ASSERTIONS
	a_skid_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output buffer overfilled");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) |-> !push)
		else $error("word pushed into full output buffer");

	a_busy_closed: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q != '0) |-> !acc)
		else $error("word taken while settings settle");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && counted && tag_c.last) |=> (t_q == '0))
		else $error("frame did not restart after last word");
`endif

endmodule
